// ===== design/bcc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_pkg
// shared types and constants for the bipartite coloring counter
// ----------------------------------------------------------------------------
package bcc_pkg;

    localparam logic [29:0] MODULUS = 30'd998244353;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_EVAL  = 2'd2;

    localparam logic [1:0] COLOR_EVEN = 2'd0;
    localparam logic [1:0] COLOR_ODD  = 2'd1;
    localparam logic [1:0] UNCOLORED  = 2'd2;

    typedef enum logic [1:0] {
        MM_DOUBLE = 2'd0,
        MM_ADD    = 2'd1,
        MM_MUL    = 2'd2
    } mm_op_t;

    // modular add of two residues
    function automatic logic [29:0] mod_add(input logic [29:0] a, input logic [29:0] b);
        logic [30:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            if (s >= {1'b0, MODULUS})
            begin
                s = s - {1'b0, MODULUS};
            end
            mod_add = s[29:0];
        end
    endfunction

endpackage
`default_nettype wire

// ===== design/bcc_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module bcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

// ===== design/bcc_modmul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_modmul
// shared modular unit: double, add, or bit-serial multiply mod 998244353
// ----------------------------------------------------------------------------
module bcc_modmul
    import bcc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire mm_op_t      op,
    input  wire logic [29:0] a,
    input  wire logic [29:0] b,
    output logic             busy,
    output logic [29:0]      result
);

    logic [29:0] acc_reg, acc_next;
    logic [29:0] mpl_reg, mpl_next;
    logic [29:0] mcand_reg, mcand_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [29:0] dbl;

    assign dbl = mod_add(acc_reg, acc_reg);

    always_comb
    begin
        acc_next   = acc_reg;
        mpl_next   = mpl_reg;
        mcand_next = mcand_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        if (start)
        begin
            case (op)
                MM_DOUBLE: acc_next = mod_add(a, a);
                MM_ADD:    acc_next = mod_add(a, b);
                MM_MUL:
                begin
                    acc_next   = 30'd0;
                    mpl_next   = b;
                    mcand_next = a;
                    cnt_next   = 5'd29;
                    busy_next  = 1'b1;
                end
                default:   acc_next = a;
            endcase
        end
        else if (busy_reg)
        begin
            // msb-first double and add
            acc_next = mpl_reg[cnt_reg] ? mod_add(dbl, mcand_reg) : dbl;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        mpl_reg   <= mpl_next;
        mcand_reg <= mcand_next;
    end

    assign busy   = busy_reg;
    assign result = acc_reg;

endmodule
`default_nettype wire

// ===== design/bipartite_coloring_counter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bipartite_coloring_counter
// two-colors a stored edge graph and counts colorings per component
// ----------------------------------------------------------------------------
// channel     dir  beat contents
// s_axis      in   tuser: cmd[1:0]; tdata: end_u[9:0], end_v[19:10]
// m_axis      out  tdata: coloring_count[29:0], is_bipartite[30], edge_overflow[31]
// node_count  in   cfg_we / cfg_data, node count in use
//
// clear sweeps the head and color rams, add links both half-edges, and
// evaluate runs a color sweep then walks each node and half-edge, with a
// modular multiply per component.
// all ram accesses go through single-port rams with one access per cycle.
// after reset a clearing pass over all MAX_NODES entries runs before s_axis_tready rises.
// a result waits in the output register; beats are taken meanwhile, but a next result holds in ST_DONE until it drains.
// ----------------------------------------------------------------------------
module bipartite_coloring_counter
    import bcc_pkg::*;
#(
    parameter int MAX_NODES      = 1024,
    parameter int MAX_HALF_EDGES = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // end_u, end_v
    input  wire logic [1:0]  s_axis_tuser,   // cmd
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // coloring_count, is_bipartite, edge_overflow
    input  wire logic        cfg_we,
    input  wire logic [10:0] cfg_data
);

    localparam int NW = $clog2(MAX_NODES);
    localparam int HW = $clog2(MAX_HALF_EDGES);
    localparam int LW = HW + 1;               // link with none marker
    localparam logic [LW-1:0] LINK_NONE = LW'(MAX_HALF_EDGES);
    localparam int CW = $clog2(MAX_NODES + 1);

    typedef enum logic [19:0] {
        ST_INIT    = 20'h00001,
        ST_IDLE    = 20'h00002,
        ST_ADD0    = 20'h00004,
        ST_ADD1    = 20'h00008,
        ST_ADD2    = 20'h00010,
        ST_ADD3    = 20'h00020,
        ST_ECLR    = 20'h00040,
        ST_SCAN    = 20'h00080,
        ST_SCANW   = 20'h00100,
        ST_ROOT    = 20'h00200,
        ST_ROOTW   = 20'h00400,
        ST_TOP     = 20'h00800,
        ST_TOPW    = 20'h01000,
        ST_LINKW   = 20'h02000,
        ST_TGTW    = 20'h04000,
        ST_COLW    = 20'h08000,
        ST_HEADW   = 20'h10000,
        ST_SUM     = 20'h20000,
        ST_MUL     = 20'h40000,
        ST_DONE    = 20'h80000
    } state_t;

    state_t state_reg, state_next;

    logic [10:0]   ncnt_reg;
    logic [NW-1:0] idx_reg, idx_next;
    logic [HW:0]   used_reg, used_next;
    logic          ovf_reg, ovf_next;
    logic [NW-1:0] u_reg, u_next, v_reg, v_next;
    logic [CW-1:0] n_lim;
    logic [CW-1:0] depth_reg, depth_next;
    logic [NW-1:0] node_reg, node_next, tgt_reg, tgt_next;
    logic [LW-1:0] link_reg, link_next_r;
    logic [1:0]    col_reg, col_next;
    logic [29:0]   pe_reg, pe_next, po_reg, po_next, ans_reg, ans_next;
    logic          ok_reg, ok_next;
    logic          ovalid_reg, ovalid_next;
    logic [31:0]   odata_reg, odata_next;
    logic          mm_started_reg, mm_started_next;

    // rams
    logic          hd_we;  logic [NW-1:0] hd_a; logic [LW-1:0] hd_wd, hd_rd;
    logic          cl_we;  logic [NW-1:0] cl_a; logic [1:0]    cl_wd, cl_rd;
    logic          ln_we;  logic [HW-1:0] ln_a; logic [LW-1:0] ln_wd, ln_rd;
    logic          lt_we;  logic [HW-1:0] lt_a; logic [NW-1:0] lt_wd, lt_rd;
    logic          sn_we;  logic [NW-1:0] sn_a; logic [NW-1:0] sn_wd, sn_rd;
    logic          sl_we;  logic [NW-1:0] sl_a; logic [LW-1:0] sl_wd, sl_rd;

    bcc_ram #(.WIDTH(LW), .DEPTH(MAX_NODES)) u_head (
        .clk(clk), .we(hd_we), .addr(hd_a), .wdata(hd_wd), .rdata(hd_rd));
    bcc_ram #(.WIDTH(2), .DEPTH(MAX_NODES)) u_color (
        .clk(clk), .we(cl_we), .addr(cl_a), .wdata(cl_wd), .rdata(cl_rd));
    bcc_ram #(.WIDTH(LW), .DEPTH(MAX_HALF_EDGES)) u_lnext (
        .clk(clk), .we(ln_we), .addr(ln_a), .wdata(ln_wd), .rdata(ln_rd));
    bcc_ram #(.WIDTH(NW), .DEPTH(MAX_HALF_EDGES)) u_ltgt (
        .clk(clk), .we(lt_we), .addr(lt_a), .wdata(lt_wd), .rdata(lt_rd));
    bcc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_snode (
        .clk(clk), .we(sn_we), .addr(sn_a), .wdata(sn_wd), .rdata(sn_rd));
    bcc_ram #(.WIDTH(LW), .DEPTH(MAX_NODES)) u_slink (
        .clk(clk), .we(sl_we), .addr(sl_a), .wdata(sl_wd), .rdata(sl_rd));

    logic        mm_start, mm_busy;
    mm_op_t      mm_op;
    logic [29:0] mm_a, mm_b, mm_res;

    bcc_modmul u_mm (
        .clk(clk), .rst_n(rst_n), .start(mm_start), .op(mm_op),
        .a(mm_a), .b(mm_b), .busy(mm_busy), .result(mm_res));

    logic [1:0]  in_cmd;
    logic [9:0]  in_u, in_v;
    logic        take;
    logic [CW-1:0] top_idx;

    assign in_cmd = s_axis_tuser;
    assign in_u   = s_axis_tdata[9:0];
    assign in_v   = s_axis_tdata[19:10];
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign take   = s_axis_tvalid && s_axis_tready;
    assign n_lim  = (32'(ncnt_reg) > 32'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(ncnt_reg);
    assign top_idx = depth_reg - CW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ncnt_reg <= 11'd1;
        end
        else if (cfg_we)
        begin
            ncnt_reg <= cfg_data;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg; used_next = used_reg; ovf_next = ovf_reg;
        u_next = u_reg; v_next = v_reg; depth_next = depth_reg;
        node_next = node_reg; tgt_next = tgt_reg; link_next_r = link_reg;
        col_next = col_reg; pe_next = pe_reg; po_next = po_reg;
        ans_next = ans_reg; ok_next = ok_reg;
        mm_started_next = mm_started_reg;
        ovalid_next = ovalid_reg && !m_axis_tready;
        odata_next = odata_reg;
        hd_we = 1'b0; hd_a = idx_reg; hd_wd = LINK_NONE;
        cl_we = 1'b0; cl_a = idx_reg; cl_wd = UNCOLORED;
        ln_we = 1'b0; ln_a = link_reg[HW-1:0]; ln_wd = hd_rd;
        lt_we = 1'b0; lt_a = link_reg[HW-1:0]; lt_wd = v_reg;
        sn_we = 1'b0; sn_a = top_idx[NW-1:0]; sn_wd = tgt_reg;
        sl_we = 1'b0; sl_a = top_idx[NW-1:0]; sl_wd = hd_rd;
        mm_start = 1'b0; mm_op = MM_DOUBLE; mm_a = pe_reg; mm_b = po_reg;

        case (state_reg)
            ST_INIT:
            begin
                hd_we = 1'b1; cl_we = 1'b1;
                idx_next = idx_reg + NW'(1);
                if (idx_reg == NW'(MAX_NODES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (take)
                begin
                    u_next = NW'(in_u);
                    v_next = NW'(in_v);
                    case (in_cmd)
                        CMD_CLEAR:
                        begin
                            idx_next = '0; used_next = '0; ovf_next = 1'b0;
                            state_next = ST_INIT;
                        end
                        CMD_ADD:
                        begin
                            if ((32'(in_u) >= 32'(MAX_NODES)) || (32'(in_v) >= 32'(MAX_NODES))
                                || (32'(used_reg) + 32'd2 > 32'(MAX_HALF_EDGES)))
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_ADD0;
                            end
                        end
                        CMD_EVAL:
                        begin
                            idx_next = '0; state_next = ST_ECLR;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD0:
            begin
                hd_a = u_reg;
                state_next = ST_ADD1;
            end
            ST_ADD1:
            begin
                // half-edge u -> v
                ln_we = 1'b1; ln_a = used_reg[HW-1:0]; ln_wd = hd_rd;
                lt_we = 1'b1; lt_a = used_reg[HW-1:0]; lt_wd = v_reg;
                hd_we = 1'b1; hd_a = u_reg; hd_wd = LW'(used_reg);
                used_next = used_reg + (HW+1)'(1);
                state_next = ST_ADD2;
            end
            ST_ADD2:
            begin
                hd_a = v_reg;
                state_next = ST_ADD3;
            end
            ST_ADD3:
            begin
                ln_we = 1'b1; ln_a = used_reg[HW-1:0]; ln_wd = hd_rd;
                lt_we = 1'b1; lt_a = used_reg[HW-1:0]; lt_wd = u_reg;
                hd_we = 1'b1; hd_a = v_reg; hd_wd = LW'(used_reg);
                used_next = used_reg + (HW+1)'(1);
                state_next = ST_IDLE;
            end
            ST_ECLR:
            begin
                cl_we = 1'b1;
                idx_next = idx_reg + NW'(1);
                ans_next = 30'd1; ok_next = 1'b1;
                if (idx_reg == NW'(MAX_NODES - 1))
                begin
                    idx_next = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (CW'(idx_reg) >= n_lim || n_lim == CW'(0))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SCANW;
                end
            end
            ST_SCANW:
            begin
                hd_a = idx_reg;
                if (cl_rd != UNCOLORED)
                begin
                    if (CW'(idx_reg) == n_lim - CW'(1))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        idx_next = idx_reg + NW'(1);
                        state_next = ST_SCAN;
                    end
                end
                else
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                // hd_rd holds head of root
                cl_we = 1'b1; cl_wd = COLOR_EVEN;
                sn_we = 1'b1; sn_a = '0; sn_wd = idx_reg;
                sl_we = 1'b1; sl_a = '0; sl_wd = hd_rd;
                pe_next = 30'd2; po_next = 30'd1;
                depth_next = CW'(1);
                state_next = ST_TOP;
            end
            ST_TOP:
            begin
                if (depth_reg == CW'(0))
                begin
                    state_next = ST_SUM;
                end
                else
                begin
                    state_next = ST_TOPW;
                end
            end
            ST_TOPW:
            begin
                node_next = sn_rd;
                link_next_r = sl_rd;
                if (sl_rd >= LINK_NONE)
                begin
                    depth_next = top_idx;
                    state_next = ST_TOP;
                end
                else
                begin
                    ln_a = sl_rd[HW-1:0]; lt_a = sl_rd[HW-1:0];
                    state_next = ST_LINKW;
                end
            end
            ST_LINKW:
            begin
                sl_we = 1'b1; sl_wd = ln_rd;
                tgt_next = lt_rd;
                if (CW'(lt_rd) >= n_lim)
                begin
                    state_next = ST_TOP;
                end
                else
                begin
                    cl_a = node_reg;
                    state_next = ST_TGTW;
                end
            end
            ST_TGTW:
            begin
                col_next = cl_rd;
                cl_a = tgt_reg;
                state_next = ST_COLW;
            end
            ST_COLW:
            begin
                hd_a = tgt_reg;
                if (cl_rd == UNCOLORED)
                begin
                    cl_we = 1'b1; cl_a = tgt_reg; cl_wd = col_reg ^ 2'd1;
                    if (col_reg == COLOR_EVEN)
                    begin
                        po_next = mod_add(po_reg, po_reg);
                    end
                    else
                    begin
                        pe_next = mod_add(pe_reg, pe_reg);
                    end
                    state_next = ST_HEADW;
                end
                else if (cl_rd == col_reg)
                begin
                    ok_next = 1'b0; ans_next = 30'd0;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_TOP;
                end
            end
            ST_HEADW:
            begin
                if (depth_reg < CW'(MAX_NODES))
                begin
                    sn_we = 1'b1; sn_a = depth_reg[NW-1:0]; sn_wd = tgt_reg;
                    sl_we = 1'b1; sl_a = depth_reg[NW-1:0]; sl_wd = hd_rd;
                    depth_next = depth_reg + CW'(1);
                end
                state_next = ST_TOP;
            end
            ST_SUM:
            begin
                mm_start = 1'b1; mm_op = MM_ADD; mm_a = pe_reg; mm_b = po_reg;
                mm_started_next = 1'b0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (!mm_started_reg)
                begin
                    mm_start = 1'b1; mm_op = MM_MUL; mm_a = ans_reg; mm_b = mm_res;
                    mm_started_next = 1'b1;
                end
                else if (!mm_busy)
                begin
                    ans_next = mm_res;
                    cl_a = idx_reg;
                    if (CW'(idx_reg) == n_lim - CW'(1))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        idx_next = idx_reg + NW'(1);
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_DONE:
            begin
                if (!ovalid_next)
                begin
                    ovalid_next = 1'b1;
                    odata_next = {ovf_reg, ok_reg, ans_reg};
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        // scan issues color read of idx
        if (state_reg == ST_SCAN)
        begin
            cl_a = idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            idx_reg        <= '0;
            used_reg       <= '0;
            ovf_reg        <= 1'b0;
            depth_reg      <= '0;
            ok_reg         <= 1'b1;
            ovalid_reg     <= 1'b0;
            mm_started_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            used_reg       <= used_next;
            ovf_reg        <= ovf_next;
            depth_reg      <= depth_next;
            ok_reg         <= ok_next;
            ovalid_reg     <= ovalid_next;
            mm_started_reg <= mm_started_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg     <= u_next;
        v_reg     <= v_next;
        node_reg  <= node_next;
        tgt_reg   <= tgt_next;
        link_reg  <= link_next_r;
        col_reg   <= col_next;
        pe_reg    <= pe_next;
        po_reg    <= po_next;
        ans_reg   <= ans_next;
        odata_reg <= odata_next;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;

endmodule
`default_nettype wire

// ===== sim/bipartite_coloring_counter_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bipartite_coloring_counter_checker
// Watches the command, result and node-count channels of the coloring
// counter, keeps its own edge store and node count, and works out the
// count, bipartite flag and overflow flag of every evaluate. Each result
// beat is compared field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module bipartite_coloring_counter_checker
    import bcc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // end_u, end_v
    input  wire logic [1:0]  s_axis_tuser,   // cmd
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [31:0] m_axis_tdata,   // coloring_count, is_bipartite, edge_overflow
    input  wire logic        cfg_we,
    input  wire logic [10:0] cfg_data,
    output int               fail_count,
    output int               results_owed
);

    localparam int NODES     = 1024;
    localparam int HALVES    = 4096;
    localparam int LINK_NONE = HALVES;
    localparam logic [63:0] MOD64 = 64'd998244353;

    typedef struct packed {
        logic        overflow;
        logic        bipartite;
        logic [29:0] count;
    } coloring_t;

    int          list_first [NODES];
    int          link_after [HALVES];
    int          link_node  [HALVES];
    logic [1:0]  paint      [NODES];
    int          stack_node [NODES];
    int          stack_link [NODES];
    int          halves_used;
    logic        dropped;
    logic [10:0] nodes_in_use;
    coloring_t   owed_q[$];

    assign results_owed = owed_q.size();

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    task automatic wipe_graph();
        for (int i = 0; i < NODES; i++)
        begin
            list_first[i] = LINK_NONE;
            paint[i] = UNCOLORED;
        end
        halves_used = 0;
        dropped = 1'b0;
    endtask

    task automatic link_half(input int from, input int to);
        link_node[halves_used] = to;
        link_after[halves_used] = list_first[from];
        list_first[from] = halves_used;
        halves_used++;
    endtask

    function automatic coloring_t color_graph();
        coloring_t   r;
        int          n, depth, top, nd, lk, t;
        logic [63:0] acc, pe, po;
        logic [1:0]  c;
        bit          ok;
        n = (int'(nodes_in_use) > NODES) ? NODES : int'(nodes_in_use);
        acc = 1;
        ok = 1;
        for (int i = 0; i < NODES; i++)
        begin
            paint[i] = UNCOLORED;
        end
        for (int i = 0; i < n && ok; i++)
        begin
            if (paint[i] == UNCOLORED)
            begin
                pe = 2;
                po = 1;
                paint[i] = COLOR_EVEN;
                stack_node[0] = i;
                stack_link[0] = list_first[i];
                depth = 1;
                while (depth > 0 && ok)
                begin
                    top = depth - 1;
                    nd = stack_node[top];
                    lk = stack_link[top];
                    if (lk >= LINK_NONE)
                    begin
                        depth = top;
                    end
                    else
                    begin
                        stack_link[top] = link_after[lk];
                        t = link_node[lk];
                        if (t < n)
                        begin
                            if (paint[t] == UNCOLORED)
                            begin
                                c = (paint[nd] == COLOR_EVEN) ? COLOR_ODD : COLOR_EVEN;
                                paint[t] = c;
                                if (c == COLOR_EVEN)
                                begin
                                    pe = (pe * 2) % MOD64;
                                end
                                else
                                begin
                                    po = (po * 2) % MOD64;
                                end
                                if (depth < NODES)
                                begin
                                    stack_node[depth] = t;
                                    stack_link[depth] = list_first[t];
                                    depth++;
                                end
                            end
                            else if (paint[t] == paint[nd])
                            begin
                                ok = 0;
                            end
                        end
                    end
                end
                if (ok)
                begin
                    acc = (acc * ((pe + po) % MOD64)) % MOD64;
                end
            end
        end
        r.count = ok ? acc[29:0] : 30'd0;
        r.bipartite = ok;
        r.overflow = dropped;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        coloring_t got, want;
        logic [1:0] cmd;
        int u, v;
        if (!rst_n)
        begin
            nodes_in_use <= 11'd1;
            wipe_graph();
            owed_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                nodes_in_use <= cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                cmd = s_axis_tuser;
                u = int'(s_axis_tdata[9:0]);
                v = int'(s_axis_tdata[19:10]);
                if (cmd == CMD_CLEAR)
                begin
                    wipe_graph();
                end
                else if (cmd == CMD_ADD)
                begin
                    if (u >= NODES || v >= NODES || halves_used + 2 > HALVES)
                    begin
                        dropped = 1'b1;
                    end
                    else
                    begin
                        link_half(u, v);
                        link_half(v, u);
                    end
                end
                else if (cmd == CMD_EVAL)
                begin
                    owed_q = {owed_q, color_graph()};
                end
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (owed_q.size() == 0)
                begin
                    report("unexpected result beat", m_axis_tdata, 32'd0);
                end
                else
                begin
                    want = owed_q.pop_front();
                    if (got.count !== want.count)
                        report("coloring_count", 32'(got.count), 32'(want.count));
                    if (got.bipartite !== want.bipartite)
                        report("is_bipartite", 32'(got.bipartite), 32'(want.bipartite));
                    if (got.overflow !== want.overflow)
                        report("edge_overflow", 32'(got.overflow), 32'(want.overflow));
                end
            end
        end
    end

    initial
    begin
        fail_count = 0;
    end

endmodule

// ===== sim/bipartite_coloring_counter_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bipartite_coloring_counter_test
// Drives clear, add-edge and evaluate beats into the coloring counter under
// several node counts and handshake idling patterns, including an edge store
// overflow and a long result back-pressure stretch, and gives the verdict
// from the failures counted by the checker, or an error when the ports fall quiet too long.
// ----------------------------------------------------------------------------
module bipartite_coloring_counter_test;
    import bcc_pkg::*;

    localparam int QUIET_LIMIT = 300000;
    localparam int SETTLE      = 1200;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        cfg_we;
    logic [10:0] cfg_data;
    int          fail_count;
    int          results_owed;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          stall_request;
    int          stall_seen;
    int          stall_left;
    int          quiet_cycles;

    bipartite_coloring_counter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data)
    );

    bipartite_coloring_counter_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .results_owed  (results_owed)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // result side: random stalls plus a long hold-off on request
    always @(posedge clk)
    begin
        if (stall_request != stall_seen)
        begin
            stall_seen = stall_request;
            stall_left = 4000;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_beat(input logic [1:0] cmd, input logic [9:0] u, input logic [9:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {4'b0000, v, u};
        do
            @(negedge clk);
        while (!s_axis_tready);
        @(posedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
        begin
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    task automatic set_node_count(input logic [10:0] n);
        drain();
        repeat (SETTLE) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= n;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // clear, random edges mostly among the first n nodes, then one or two evaluates
    task automatic graph_burst(input int n);
        int  edges, span, u, v;
        bit  split;
        logic [1023:0] side;
        span = (n < 2) ? 2 : ((n > 1024) ? 1024 : n);
        edges = $urandom_range(24);
        split = ($urandom_range(2) != 0);
        for (int i = 0; i < 1024; i++)
        begin
            side[i] = 1'($urandom_range(1));
        end
        send_beat(CMD_CLEAR, 10'($urandom), 10'($urandom));
        for (int e = 0; e < edges; e++)
        begin
            u = $urandom_range(span - 1);
            v = $urandom_range(span - 1);
            if ($urandom_range(15) == 0)
            begin
                v = $urandom_range(1023);
            end
            else if (split && side[u] == side[v])
            begin
                if ($urandom_range(20) != 0)
                begin
                    continue;
                end
            end
            send_beat(CMD_ADD, 10'(u), 10'(v));
            if ($urandom_range(30) == 0)
            begin
                send_beat(CMD_SPARE, 10'($urandom), 10'($urandom));
            end
        end
        send_beat(CMD_EVAL, 10'($urandom), 10'($urandom));
        if ($urandom_range(5) == 0)
        begin
            send_beat(CMD_EVAL, 10'($urandom), 10'($urandom));
        end
    endtask

    task automatic random_phase(input int bursts);
        int pick;
        logic [10:0] sizes [5] = '{11'd1, 11'd2, 11'd9, 11'd40, 11'd200};
        for (int b = 0; b < bursts; b++)
        begin
            if (b % 8 == 0)
            begin
                pick = $urandom_range(4);
                set_node_count(sizes[pick]);
            end
            graph_burst(int'(sizes[pick]));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_request = 0;
        stall_seen = 0;
        stall_left = 0;
        quiet_cycles = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed cases
        send_beat(CMD_EVAL, 10'd0, 10'd0);
        set_node_count(11'd4);
        send_beat(CMD_EVAL, 10'd0, 10'd0);
        send_beat(CMD_ADD, 10'd0, 10'd1);
        send_beat(CMD_ADD, 10'd1, 10'd2);
        send_beat(CMD_EVAL, 10'd0, 10'd0);
        send_beat(CMD_ADD, 10'd2, 10'd0);
        send_beat(CMD_EVAL, 10'd0, 10'd0);
        send_beat(CMD_CLEAR, 10'd1023, 10'd1023);
        send_beat(CMD_ADD, 10'd3, 10'd3);
        send_beat(CMD_EVAL, 10'd0, 10'd0);
        send_beat(CMD_CLEAR, 10'd0, 10'd0);
        send_beat(CMD_ADD, 10'd0, 10'd1023);
        send_beat(CMD_ADD, 10'd1023, 10'd1023);
        send_beat(CMD_SPARE, 10'd1023, 10'd1023);
        send_beat(CMD_EVAL, 10'd1023, 10'd1023);
        set_node_count(11'd0);
        send_beat(CMD_EVAL, 10'd0, 10'd0);
        set_node_count(11'd2047);
        send_beat(CMD_EVAL, 10'd0, 10'd0);
        set_node_count(11'd1024);
        send_beat(CMD_EVAL, 10'd0, 10'd0);

        // edge store overflow
        send_beat(CMD_CLEAR, 10'd0, 10'd0);
        for (int e = 0; e < 2050; e++)
        begin
            send_beat(CMD_ADD, 10'($urandom), 10'($urandom));
        end
        send_beat(CMD_EVAL, 10'd0, 10'd0);
        send_beat(CMD_CLEAR, 10'd0, 10'd0);
        send_beat(CMD_EVAL, 10'd0, 10'd0);

        send_idle_pct = 32;
        recv_idle_pct = 70;
        random_phase(12);
        send_idle_pct = 70;
        recv_idle_pct = 32;
        random_phase(12);
        send_idle_pct = 0;
        recv_idle_pct = 0;

        // long result hold-off while evaluates keep coming
        set_node_count(11'd3);
        stall_request++;
        for (int k = 0; k < 6; k++)
        begin
            send_beat(CMD_ADD, 10'($urandom_range(3)), 10'($urandom_range(3)));
            send_beat(CMD_EVAL, 10'($urandom), 10'($urandom));
        end
        drain();
        random_phase(12);

        drain();
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
